### design/ufds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufds_pkg
// Shared types, character constants and helpers of the form decoder.
// ----------------------------------------------------------------------------
package ufds_pkg;

   localparam int MAX_RESULTS = 4;
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int SLOT_W      = $clog2(MAX_RESULTS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_THREE   = 8'h33;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_C = 8'h43;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_APOS    = 8'h27;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_LOWER_N = 8'h6E;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_LOWER_L = 8'h6C;
   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam logic [7:0] CH_NUL     = 8'h00;

   typedef enum logic [1:0] {
      PHASE_NORMAL  = 2'd0,
      PHASE_PERCENT = 2'd1,
      PHASE_HELD    = 2'd2,
      PHASE_SPARE   = 2'd3
   } phase_type;

   // one queue entry: the results caused by one input transfer
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [COUNT_W-1:0]          count;
      logic                        no_byte;
      logic                        last;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [7:0] sanitize(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c == CH_SEMI || c == CH_APOS || c == CH_QUOTE) begin
         r = CH_SPACE;
      end
      return r;
   endfunction

endpackage

### design/url_form_decode_sanitize_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_form_decode_sanitize_unit
// Form-encoded string decoder with sanitizing of the decoded characters.
//
//   channel | dir | tdata        | tuser   | tlast
//   req_    | in  | byte_in      | -       | last_in
//   rsp_    | out | byte_out     | no_byte | last_out
//
// one input transfer per cycle while the four-entry queue has room
// each result group leaves one character per cycle while the output is not stalled;
// escapes %0A and %3C expand to three and four characters on the output side
// the results of an input transfer pass through the queue into the output register
// reset clears escape state, queue pointers and the valid flag of the output register
// ----------------------------------------------------------------------------
module url_form_decode_sanitize_unit
   import ufds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_in
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] byte_out
   output logic       rsp_tuser,   // [0] no_byte
   output logic       rsp_tlast
);

   logic             take;
   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head;
   queue_status_type status;

   assign req_tready = status.not_full;
   assign take       = req_tvalid && req_tready;

   ufds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .byte_in    (req_tdata),
      .last_in    (req_tlast),
      .push       (push),
      .push_entry (push_entry)
   );

   ufds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   ufds_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### design/ufds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufds_front
// Takes one encoded character per transfer, tracks escapes and builds the
// group of decoded characters that it causes.
// ----------------------------------------------------------------------------
module ufds_front
   import ufds_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [7:0]       byte_in,
   input  logic             last_in,
   output logic             push,
   output entry_type        push_entry
);

   phase_type  phase_ff, phase_in;
   logic [7:0] first_ff, first_in;
   logic       ended_ff, ended_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_NORMAL;
         first_ff <= CH_NUL;
         ended_ff <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in;
         first_ff <= first_in;
         ended_ff <= ended_in;
      end
   end

   always_comb begin
      logic [7:0]         c;
      logic [4:0]         hi;
      logic [4:0]         lo;
      logic [7:0]         v;
      logic [COUNT_W-1:0] n;
      logic               can_emit;
      c          = (byte_in == CH_PLUS) ? CH_SPACE : byte_in;
      hi         = hex_digit(first_ff);
      lo         = hex_digit(c);
      v          = CH_NUL;
      n          = '0;
      can_emit   = !ended_ff;
      phase_in   = PHASE_NORMAL;
      first_in   = first_ff;
      ended_in   = ended_ff;
      push_entry = '0;
      case (phase_ff)
         PHASE_PERCENT: begin
            if (c == CH_NUL) begin
               ended_in = 1'b1;
            end else begin
               first_in = c;
               phase_in = PHASE_HELD;
            end
         end
         PHASE_HELD: begin
            if (c == CH_NUL) begin
               ended_in = 1'b1;
            end else if (first_ff == CH_ZERO && c == CH_UPPER_A) begin
               if (can_emit) begin
                  push_entry.bytes[0] = CH_BSLASH;
                  push_entry.bytes[1] = CH_BSLASH;
                  push_entry.bytes[2] = CH_LOWER_N;
                  n = COUNT_W'(3);
               end
            end else if (first_ff == CH_THREE && c == CH_UPPER_C) begin
               if (can_emit) begin
                  push_entry.bytes[0] = CH_AMP;
                  push_entry.bytes[1] = CH_LOWER_L;
                  push_entry.bytes[2] = CH_LOWER_T;
                  push_entry.bytes[3] = CH_SPACE;
                  n = COUNT_W'(4);
               end
            end else begin
               if (!hi[4]) begin
                  v = CH_NUL;
               end else if (!lo[4]) begin
                  v = {4'd0, hi[3:0]};
               end else begin
                  v = {hi[3:0], lo[3:0]};
               end
               if (can_emit) begin
                  if (v == CH_NUL) begin
                     ended_in = 1'b1;
                  end else begin
                     push_entry.bytes[0] = sanitize(v);
                     n = COUNT_W'(1);
                  end
               end
            end
         end
         default: begin
            if (c == CH_PERCENT) begin
               if (!ended_ff) begin
                  phase_in = PHASE_PERCENT;
               end
            end else if (can_emit) begin
               if (c == CH_NUL) begin
                  ended_in = 1'b1;
               end else begin
                  push_entry.bytes[0] = sanitize(c);
                  n = COUNT_W'(1);
               end
            end
         end
      endcase
      if (ended_in) begin
         phase_in = PHASE_NORMAL;
      end
      if (last_in) begin
         phase_in = PHASE_NORMAL;
         first_in = CH_NUL;
         ended_in = 1'b0;
      end
      push_entry.last    = last_in;
      push_entry.no_byte = 1'b0;
      push_entry.count   = n;
      if (last_in && n == '0) begin
         push_entry.no_byte = 1'b1;
         push_entry.count   = COUNT_W'(1);
         push_entry.bytes   = '0;
      end
      push = take && (push_entry.count != '0);
   end

endmodule

### design/ufds_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufds_queue
// Short queue of result groups between the classifier and the serializer.
// ----------------------------------------------------------------------------
module ufds_queue
   import ufds_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   entry_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   assign head             = entries_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.not_full  = (count_ff != QCNT_W'(QUEUE_DEPTH));

endmodule

### design/ufds_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufds_back
// Walks the head group of the queue one character per transfer into the
// output register.
// ----------------------------------------------------------------------------
module ufds_back
   import ufds_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  entry_type        head,
   input  queue_status_type status,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              valid_ff, valid_in;
   logic [7:0]        data_ff, data_in;
   logic              user_ff, user_in;
   logic              last_ff, last_in;
   logic              load;
   logic              final_slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
   end

   always_comb begin
      load       = status.not_empty && (!valid_ff || rsp_tready);
      final_slot = (slot_ff == SLOT_W'(head.count - 1'b1));
      pop        = load && final_slot;
      data_in    = head.bytes[slot_ff];
      user_in    = head.no_byte;
      last_in    = head.last && final_slot;
      slot_in    = slot_ff;
      if (load) begin
         slot_in = final_slot ? '0 : SLOT_W'(slot_ff + 1'b1);
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

### tb/sv/url_form_decode_sanitize_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_form_decode_sanitize_unit_tb
// Self-checking bench for the form decoder. A queue of encoded characters
// feeds a stream driver. Every accepted character runs through a local
// decoder model, and the characters it should produce are queued. A monitor
// compares each output transfer with the oldest queued character. The run has
// directed strings, random strings that mix escapes with other characters, a
// long output stall, and phases with random gaps on both sides.
// ----------------------------------------------------------------------------
module url_form_decode_sanitize_unit_tb;
   import ufds_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 150;
   localparam int PHASE_ITEMS  = 67;
   localparam int TAIL_CYCLES  = 20;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } enc_char_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       no_byte;
      logic       last;
   } dec_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] byte_in
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] byte_out
   logic       rsp_tuser;           // [0] no_byte
   logic       rsp_tlast;

   enc_char_type   char_queue[$];
   dec_result_type decoded_fifo[$];
   logic [7:0]     step_chars[$];

   phase_type  esc_phase = PHASE_NORMAL;
   logic [7:0] held_char = 8'h00;
   logic       text_ended = 1'b0;

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  chars_added = 0;
   int  errors = 0;
   int  quiet_cycles = 0;
   int  hold_left = 0;
   bit  hold_request = 1'b0;
   bit  req_taken = 1'b0;

   string hex_chars = "0123456789abcdefABCDEF";

   url_form_decode_sanitize_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic int digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic void put_char(input logic [7:0] c);
      if (text_ended) return;
      if (c == CH_NUL) begin
         text_ended = 1'b1;
         return;
      end
      if (c == CH_SEMI || c == CH_APOS || c == CH_QUOTE) begin
         step_chars.push_back(CH_SPACE);
      end else begin
         step_chars.push_back(c);
      end
   endfunction

   task automatic predict_decode(input logic [7:0] raw, input logic fin);
      logic [7:0]     c;
      int             hi;
      int             lo;
      dec_result_type r;
      c = (raw == CH_PLUS) ? CH_SPACE : raw;
      step_chars.delete();
      case (esc_phase)
         PHASE_PERCENT: begin
            if (c == CH_NUL) begin
               text_ended = 1'b1;
               esc_phase  = PHASE_NORMAL;
            end else begin
               held_char = c;
               esc_phase = PHASE_HELD;
            end
         end
         PHASE_HELD: begin
            esc_phase = PHASE_NORMAL;
            if (c == CH_NUL) begin
               text_ended = 1'b1;
            end else if (held_char == CH_ZERO && c == CH_UPPER_A) begin
               put_char(CH_BSLASH);
               put_char(CH_BSLASH);
               put_char(CH_LOWER_N);
            end else if (held_char == CH_THREE && c == CH_UPPER_C) begin
               put_char(CH_AMP);
               put_char(CH_LOWER_L);
               put_char(CH_LOWER_T);
               put_char(CH_SEMI);
            end else begin
               hi = digit_value(held_char);
               lo = digit_value(c);
               if (hi < 0) begin
                  put_char(CH_NUL);
               end else if (lo < 0) begin
                  put_char(hi[7:0]);
               end else begin
                  put_char(8'(hi * 16 + lo));
               end
            end
         end
         default: begin
            esc_phase = PHASE_NORMAL;
            if (c == CH_PERCENT) begin
               if (!text_ended) esc_phase = PHASE_PERCENT;
            end else begin
               put_char(c);
            end
         end
      endcase
      if (text_ended) esc_phase = PHASE_NORMAL;
      foreach (step_chars[i]) begin
         r.ch      = step_chars[i];
         r.no_byte = 1'b0;
         r.last    = fin && (i == step_chars.size() - 1);
         decoded_fifo.push_back(r);
      end
      if (fin) begin
         if (step_chars.size() == 0) begin
            r.ch      = 8'h00;
            r.no_byte = 1'b1;
            r.last    = 1'b1;
            decoded_fifo.push_back(r);
         end
         esc_phase  = PHASE_NORMAL;
         held_char  = 8'h00;
         text_ended = 1'b0;
      end
   endtask

   task automatic add_char(input logic [7:0] c, input logic fin);
      enc_char_type e;
      e.ch  = c;
      e.fin = fin;
      char_queue.push_back(e);
      chars_added++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_char(s[i], i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] pick_hex();
      if ($urandom_range(99) < 10) return 8'($urandom_range(255));
      return hex_chars[$urandom_range(hex_chars.len() - 1)];
   endfunction

   task automatic add_random_text();
      logic [7:0] buf_chars[$];
      int         tokens;
      int         r;
      tokens = $urandom_range(1, 6);
      repeat (tokens) begin
         r = $urandom_range(99);
         if (r < 25) begin
            buf_chars.push_back(CH_PERCENT);
            buf_chars.push_back(pick_hex());
            buf_chars.push_back(pick_hex());
         end else if (r < 32) begin
            buf_chars.push_back(CH_PERCENT);
            if ($urandom_range(1)) begin
               buf_chars.push_back(CH_ZERO);
               buf_chars.push_back(CH_UPPER_A);
            end else begin
               buf_chars.push_back(CH_THREE);
               buf_chars.push_back(CH_UPPER_C);
            end
         end else if (r < 42) begin
            buf_chars.push_back(CH_PLUS);
         end else if (r < 50) begin
            case ($urandom_range(2))
               0:       buf_chars.push_back(CH_SEMI);
               1:       buf_chars.push_back(CH_APOS);
               default: buf_chars.push_back(CH_QUOTE);
            endcase
         end else if (r < 53) begin
            buf_chars.push_back(CH_NUL);
         end else if (r < 75) begin
            buf_chars.push_back(pick_hex());
         end else begin
            buf_chars.push_back(8'($urandom_range(255)));
         end
      end
      // sometimes cut the tail so that an escape may be left unfinished
      if (buf_chars.size() > 1 && $urandom_range(99) < 12) begin
         void'(buf_chars.pop_back());
      end
      foreach (buf_chars[i]) begin
         add_char(buf_chars[i], i == buf_chars.size() - 1);
      end
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (char_queue.size() != 0 || req_tvalid || decoded_fifo.size() != 0);
   endtask

   // input driver
   always @(negedge clock) begin
      enc_char_type e;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            e = char_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= e.ch;
            req_tlast  <= e.fin;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // output back-pressure
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      dec_result_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            predict_decode(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_fifo.size() == 0) begin
               $display("%0t: unexpected transfer actual byte=%h no_byte=%b last=%b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               errors++;
            end else begin
               want = decoded_fifo.pop_front();
               if (want.no_byte != rsp_tuser || want.last != rsp_tlast ||
                   (!want.no_byte && want.ch != rsp_tdata)) begin
                  $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b",
                           $time, want.ch, want.no_byte, want.last,
                           rsp_tdata, rsp_tuser, rsp_tlast);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         if (p == 0) begin
            add_text("a+b;");
            add_text("%0A");
            add_text("%3C");
            add_text("%3c'");
            add_text("%zz\"");
            add_text("%4z%2+");
            add_char(8'hFF, 1'b0);
            add_char(CH_PERCENT, 1'b0);
            add_char(CH_NUL, 1'b1);
            add_text("%4");
            wait_drained();
            hold_request = 1'b1;
         end
         chars_added = 0;
         while (chars_added < PHASE_ITEMS) add_random_text();
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
design/ufds_pkg.sv
design/ufds_front.sv
design/ufds_queue.sv
design/ufds_back.sv
design/url_form_decode_sanitize_unit.sv
tb/sv/url_form_decode_sanitize_unit_tb.sv
